[hdl/b64d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // classifier codes above the 64 symbol values
  localparam logic [6:0] CLASS_PAD   = 7'd64;
  localparam logic [6:0] CLASS_SPACE = 7'd65;
  localparam logic [6:0] CLASS_BAD   = 7'd66;

  // configuration register indexes
  localparam logic [1:0] REG_URL_SAFE     = 2'd0;
  localparam logic [1:0] REG_SKIP_SPACE   = 2'd1;
  localparam logic [1:0] REG_PADDING_MODE = 2'd2;

  // padding modes; mode three behaves as required
  localparam logic [1:0] PAD_REJECT   = 2'd0;
  localparam logic [1:0] PAD_OPTIONAL = 2'd1;
  localparam logic [1:0] PAD_REQUIRED = 2'd2;

  typedef enum logic [1:0] {
    STATUS_BUSY = 2'd0,
    STATUS_OK   = 2'd1,
    STATUS_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic       url_safe;
    logic       skip_space;
    logic [1:0] padding_mode;
  } cfg_t;

  // results of one request: up to three bytes, count 0 means a single empty result
  typedef struct packed {
    logic [2:0][7:0] octets;
    logic [1:0]      count;
    status_t         status;
  } result_t;

  function automatic logic [6:0] classify(input logic [7:0] c, input logic url_safe);
    logic [6:0] cls;
    case (c) inside
      [8'h41:8'h5A]: cls = 7'(c - 8'h41);           // A..Z
      [8'h61:8'h7A]: cls = 7'(c - 8'h61 + 8'd26);   // a..z
      [8'h30:8'h39]: cls = 7'(c - 8'h30 + 8'd52);   // 0..9
      8'h2B:         cls = url_safe ? CLASS_BAD : 7'd62;   // '+'
      8'h2F:         cls = url_safe ? CLASS_BAD : 7'd63;   // '/'
      8'h2D:         cls = url_safe ? 7'd62 : CLASS_BAD;   // '-'
      8'h5F:         cls = url_safe ? 7'd63 : CLASS_BAD;   // '_'
      8'h3D:         cls = CLASS_PAD;                      // '='
      8'h20, 8'h09, 8'h0A: cls = CLASS_SPACE;
      default:       cls = CLASS_BAD;
    endcase
    return cls;
  endfunction

endpackage

[hdl/b64d_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_core
// Decoder state and the per-character decode step. The result of a request is
// formed combinationally from the request and the current state; state moves
// on the accepting edge.
// ----------------------------------------------------------------------------
module b64d_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       char_code,
  input  logic             msg_end,
  input  b64d_pkg::cfg_t   cfg,
  output b64d_pkg::result_t result
);

  logic [5:0] held_symbols [3];
  logic [1:0] held_count, held_count_next;
  logic [1:0] pad_count, pad_count_next;
  logic       group_padded, group_padded_next;
  logic       error_flag, error_flag_next;
  logic       store_en;

  logic [6:0] cls;
  logic       allow_pad, require_pad, partial_ok, fail;
  logic [5:0] last_sym;

  assign allow_pad   = cfg.padding_mode != b64d_pkg::PAD_REJECT;
  assign require_pad = cfg.padding_mode[1];
  assign cls         = b64d_pkg::classify(char_code, cfg.url_safe);

  // unused low bits of a partial group must be zero
  always_comb begin
    case (held_count)
      2'd3:    partial_ok = held_symbols[2][1:0] == 2'b00;
      2'd2:    partial_ok = held_symbols[1][3:0] == 4'b0000;
      default: partial_ok = 1'b0;
    endcase
  end

  always_comb begin
    held_count_next   = held_count;
    pad_count_next    = pad_count;
    group_padded_next = group_padded;
    error_flag_next   = error_flag;
    store_en          = 1'b0;
    fail              = 1'b0;
    last_sym          = 6'd0;
    result.count      = 2'd0;
    result.status     = b64d_pkg::STATUS_BUSY;

    if (error_flag) begin
      result.status = b64d_pkg::STATUS_ERR;
    end else if (msg_end) begin
      if (group_padded || (pad_count == 2'd0 && held_count == 2'd0)) begin
        result.status = b64d_pkg::STATUS_OK;
      end else if (pad_count == 2'd0 && !require_pad && partial_ok) begin
        result.status = b64d_pkg::STATUS_OK;
        result.count  = held_count - 2'd1;
      end else begin
        fail = 1'b1;
      end
      held_count_next   = 2'd0;
      pad_count_next    = 2'd0;
      group_padded_next = 1'b0;
    end else if (cls < b64d_pkg::CLASS_PAD) begin
      if (pad_count != 2'd0 || group_padded) begin
        fail = 1'b1;
      end else if (held_count != 2'd3) begin
        store_en        = 1'b1;
        held_count_next = held_count + 2'd1;
      end else begin
        last_sym        = cls[5:0];
        result.count    = 2'd3;
        held_count_next = 2'd0;
      end
    end else if (cls == b64d_pkg::CLASS_SPACE) begin
      fail = !cfg.skip_space;
    end else if (cls == b64d_pkg::CLASS_PAD) begin
      if (!allow_pad || group_padded || !partial_ok) begin
        fail = 1'b1;
      end else if ({1'b0, held_count} + {1'b0, pad_count} + 3'd1 == 3'd4) begin
        // padding completes the group
        result.count      = held_count - 2'd1;
        held_count_next   = 2'd0;
        pad_count_next    = 2'd0;
        group_padded_next = 1'b1;
      end else begin
        pad_count_next = pad_count + 2'd1;
      end
    end else begin
      fail = 1'b1;
    end

    if (fail) begin
      error_flag_next = 1'b1;
      result.status   = b64d_pkg::STATUS_ERR;
      result.count    = 2'd0;
    end

    result.octets[0] = {held_symbols[0], held_symbols[1][5:4]};
    result.octets[1] = {held_symbols[1][3:0], held_symbols[2][5:2]};
    result.octets[2] = {held_symbols[2][1:0], last_sym};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      pad_count    <= 2'd0;
      group_padded <= 1'b0;
      error_flag   <= 1'b0;
    end else if (accept) begin
      held_count   <= held_count_next;
      pad_count    <= pad_count_next;
      group_padded <= group_padded_next;
      error_flag   <= error_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      held_symbols[held_count] <= cls[5:0];
    end
  end

endmodule

[hdl/base64_strict_stream_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_strict_stream_decoder
// Strict base64 decoder, one character or end marker per request.
//
//   channel  | direction | payload
//   s_*      | in        | tdata: char_code[7:0]; tuser: msg_end
//   m_*      | out       | tdata: out_byte[7:0], status[9:8]; tuser: byte_valid; tlast
//   cfg_*    | in        | index 0 url_safe, 1 skip_space, 2 padding_mode
//
// A request is decoded in the accepting cycle and its one to three results are
// held in an output buffer, which drains one result per cycle while m_tready is
// high. Throughput is one request per cycle while each request yields one result
// and m_tready stays high; a request that yields more bytes stalls the input.
// The input is taken while the last buffered result leaves, so m_tready stalls
// propagate without a bubble. Reset is synchronous and resets state and config.
// ----------------------------------------------------------------------------
module base64_strict_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code[7:0]
  input  logic        s_tuser,   // msg_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_byte[7:0], status[9:8], zero [15:10]
  output logic        m_tuser,   // byte_valid
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_wdata
);

  b64d_pkg::cfg_t    cfg;
  b64d_pkg::result_t result;
  logic              accept;

  logic              out_valid;
  logic [1:0]        out_remain;
  logic              out_has_byte;
  logic [2:0][7:0]   out_octets;
  b64d_pkg::status_t out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.url_safe     <= 1'b0;
      cfg.skip_space   <= 1'b0;
      cfg.padding_mode <= b64d_pkg::PAD_OPTIONAL;
    end else if (cfg_we) begin
      case (cfg_index)
        b64d_pkg::REG_URL_SAFE:     cfg.url_safe     <= cfg_wdata[0];
        b64d_pkg::REG_SKIP_SPACE:   cfg.skip_space   <= cfg_wdata[0];
        b64d_pkg::REG_PADDING_MODE: cfg.padding_mode <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_tready = !out_valid || (m_tready && out_remain == 2'd1);
  assign accept   = s_tvalid && s_tready;

  b64d_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (s_tdata),
    .msg_end      (s_tuser),
    .cfg          (cfg),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      out_remain <= 2'd0;
    end else if (accept) begin
      out_valid  <= 1'b1;
      out_remain <= (result.count == 2'd0) ? 2'd1 : result.count;
    end else if (out_valid && m_tready) begin
      if (out_remain == 2'd1) begin
        out_valid <= 1'b0;
      end
      out_remain <= out_remain - 2'd1;
    end
  end

  // payload: load on accept, shift the next byte down as each result leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      out_octets   <= result.octets;
      out_has_byte <= result.count != 2'd0;
      out_status   <= result.status;
    end else if (out_valid && m_tready) begin
      out_octets[0] <= out_octets[1];
      out_octets[1] <= out_octets[2];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_status, out_has_byte ? out_octets[0] : 8'd0};
  assign m_tuser  = out_has_byte;
  assign m_tlast  = out_remain == 2'd1;

endmodule
